[sv/roulette_wheel_selector_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef ROULETTE_WHEEL_SELECTOR_CORE_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/rws_pkg.sv]
package rws_pkg;

  // Field widths fixed by the word formats
  localparam int KEY_BITS    = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int RANDOM_BITS = 16;
  localparam int COUNT_BITS  = 7;

  // Opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CHANGE = 2'd1;
  localparam logic [1:0] OP_DRAW   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [KEY_BITS-1:0]    key;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RANDOM_BITS-1:0] random_value;
  } in_word_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   selected_key;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] item_count;
  } out_word_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

endpackage

[sv/rws_mem.sv]
module rws_mem
  import rws_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/rws_ctrl.sv]
module rws_ctrl
  import rws_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int IDX_W     = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             res_valid,
  output out_word_t        res_word,
  input  logic             res_taken,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output entry_t           wr_data,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_addr,
  input  entry_t           rd_data
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W  = WEIGHT_BITS + $clog2(MAX_ITEMS);
  localparam int PROD_W = SUM_W + RANDOM_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WALK = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  total;
  in_word_t          cur;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  run;
  logic [CNT_W-1:0]  issue_idx;
  logic              dv;
  logic [CNT_W-1:0]  dv_idx;
  out_word_t         res;

  logic             accept;
  logic             walk_last;
  logic             key_hit;
  logic [SUM_W-1:0] run_next;
  logic [SUM_W-1:0] thr;
  logic             room;

  // Datapath helpers
  always_comb begin
    in_ready  = (state == S_IDLE);
    accept    = in_valid && in_ready;
    room      = (cnt < CNT_W'(MAX_ITEMS));
    walk_last = (dv_idx == cnt - CNT_W'(1));
    key_hit   = (rd_data.key == cur.key);
    run_next  = run + SUM_W'(rd_data.weight);
    thr       = prod[PROD_W-1:RANDOM_BITS];
    res_valid = (state == S_FIN);
    res_word  = res;
  end

  // Memory access: reads stream during a walk, writes on an add with room or on a change key hit
  always_comb begin
    rd_en   = (state == S_WALK) && (issue_idx < cnt);
    rd_addr = issue_idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt[IDX_W-1:0];
    wr_data = '{key: in_data.key, weight: in_data.weight};
    if (accept && in_data.opcode == OP_ADD && room) begin
      wr_en = 1'b1;
    end else if (state == S_WALK && dv && cur.opcode == OP_CHANGE && key_hit) begin
      wr_en   = 1'b1;
      wr_addr = dv_idx[IDX_W-1:0];
      wr_data = '{key: cur.key, weight: cur.weight};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      total     <= '0;
      dv        <= 1'b0;
      issue_idx <= '0;
    end else begin
      dv     <= rd_en;
      dv_idx <= issue_idx;
      if (rd_en) begin
        issue_idx <= issue_idx + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur                <= in_data;
            run                <= '0;
            issue_idx          <= '0;
            res.selected_key   <= '0;
            res.status         <= ST_OK;
            res.item_count     <= COUNT_BITS'(cnt);
            state              <= S_FIN;
            case (in_data.opcode)
              OP_ADD: begin
                if (room) begin
                  cnt            <= cnt + CNT_W'(1);
                  total          <= total + SUM_W'(in_data.weight);
                  res.item_count <= COUNT_BITS'(cnt + CNT_W'(1));
                end else begin
                  res.status <= ST_FULL;
                end
              end
              OP_CHANGE: begin
                if (cnt == '0) begin
                  res.status <= ST_NOT_FOUND;
                end else begin
                  state <= S_WALK;
                end
              end
              OP_DRAW: begin
                if (cnt == '0) begin
                  res.status <= ST_EMPTY;
                end else begin
                  state <= S_MUL;
                end
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_MUL: begin
          // threshold = (random * total) >> RANDOM_BITS, shift taken at the compare
          prod  <= PROD_W'(cur.random_value) * PROD_W'(total);
          state <= S_WALK;
        end
        S_WALK: begin
          if (dv) begin
            if (cur.opcode == OP_CHANGE) begin
              if (key_hit) begin
                total <= total - SUM_W'(rd_data.weight) + SUM_W'(cur.weight);
                state <= S_FIN;
              end else if (walk_last) begin
                res.status <= ST_NOT_FOUND;
                state      <= S_FIN;
              end
            end else begin
              run <= run_next;
              // zero total never passes the threshold: last entry wins
              if (run_next > thr || walk_last) begin
                res.selected_key <= rd_data.key;
                state            <= S_FIN;
              end
            end
          end
        end
        S_FIN: begin
          if (res_taken) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/roulette_wheel_selector_core.sv]
// Roulette-wheel selector: a table of up to MAX_ITEMS key/weight entries in one
// single-port-read memory, with add, change-weight and weighted draw operations.
// One word is processed at a time. Add and rejected operations go from accept
// straight to the finish state; change weight and draw walk the memory one entry
// per cycle through its registered read port, stopping early on a key hit or a
// selected entry (draw adds a multiply step before the walk). A finished result
// sits in an output register, so the next word is accepted while it waits to be
// taken. The running weight total is kept in a register, so a draw needs one pass
// only. Table contents are undefined until written; only entries below the fill
// count are ever read, so no clearing pass is needed after reset.
module roulette_wheel_selector_core
  import rws_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IDX_W = $clog2(MAX_ITEMS);

  logic             res_valid;
  out_word_t        res_word;
  logic             res_taken;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  rws_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_word  (res_word),
    .res_taken (res_taken),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  rws_mem #(
    .DEPTH (MAX_ITEMS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: takes a result when empty or being drained
  assign res_taken = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_taken) begin
      out_valid <= 1'b1;
      out_data  <= res_word;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[sv/rws_checker.sv]
`include "roulette_wheel_selector_core_macros.svh"

module rws_checker
  import rws_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A waiting input word holds
  `RWS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data), "in word changed while waiting")

  // A stalled result word holds
  `RWS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed while stalled")

  // One word in flight: no accept in the cycle after an accept
  `RWS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input accepted back to back")

  // Full is only reported with the table at capacity
  `RWS_ASSERT_NOW(a_full_count, out_valid && out_data.status == ST_FULL, out_data.item_count == COUNT_BITS'(MAX_ITEMS), "full status with wrong count")

  // Empty draw reports no entries and no key
  `RWS_ASSERT_NOW(a_empty_draw, out_valid && out_data.status == ST_EMPTY, out_data.item_count == '0 && out_data.selected_key == '0, "empty status with entries or key")

endmodule

bind roulette_wheel_selector_core rws_checker #(
  .MAX_ITEMS (MAX_ITEMS)
) u_rws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[tb/sv/roulette_wheel_selector_core_tb.sv]
`timescale 1ns / 100ps

module roulette_wheel_selector_core_tb;
  import rws_pkg::*;

  localparam int TABLE_DEPTH     = 64;
  localparam logic [1:0] OP_NONE = 2'd3;   // spare opcode, does nothing
  localparam int RANDOM_WORDS    = 1350;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 200;    // well past a full-table draw
  localparam int MAX_PRINTS      = 100;

  typedef struct {
    in_word_t  word;
    int        reps;    // repeated adds bump the key by one each time
    bit        typed;   // expected word given in the row itself
    out_word_t exp;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Shadow copy of the weight table
  logic [KEY_BITS-1:0]    table_keys    [TABLE_DEPTH];
  logic [WEIGHT_BITS-1:0] table_weights [TABLE_DEPTH];
  int                     table_count = 0;

  out_word_t expected_q[$];
  int        err_count = 0;
  bit        calm = 1'b0;      // both sides run without gaps while set
  bit        hold_req = 1'b0;  // asks the receiver for one long hold-off

  roulette_wheel_selector_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Apply one word to the shadow table and return the result it gives
  function automatic out_word_t apply_to_table(in_word_t w);
    out_word_t   res;
    logic [63:0] total;
    logic [63:0] run;
    logic [63:0] thr;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (w.opcode)
      OP_ADD: begin
        if (table_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          table_keys[table_count]    = w.key;
          table_weights[table_count] = w.weight;
          table_count++;
        end
      end
      OP_CHANGE: begin
        for (int i = 0; i < table_count && !hit; i++) begin
          if (table_keys[i] == w.key) begin
            table_weights[i] = w.weight;
            hit = 1'b1;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      OP_DRAW: begin
        if (table_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          total = '0;
          run   = '0;
          for (int i = 0; i < table_count; i++) total += table_weights[i];
          thr = (64'(w.random_value) * total) >> RANDOM_BITS;
          for (int i = 0; i < table_count && !hit; i++) begin
            run += table_weights[i];
            if (run > thr) begin
              res.selected_key = table_keys[i];
              hit = 1'b1;
            end
          end
          // zero total weight: last entry wins
          if (!hit) res.selected_key = table_keys[table_count-1];
        end
      end
      default: ;
    endcase
    res.item_count = COUNT_BITS'(table_count);
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic stim_row_t mk_row(logic [1:0] op, logic [15:0] key, logic [15:0] wt,
                                       logic [15:0] rnd, int reps, bit typed,
                                       logic [15:0] sel, logic [1:0] st, int cnt);
    stim_row_t r;
    r.word.opcode       = op;
    r.word.key          = key;
    r.word.weight       = wt;
    r.word.random_value = rnd;
    r.reps              = reps;
    r.typed             = typed;
    r.exp.selected_key  = sel;
    r.exp.status        = st;
    r.exp.item_count    = COUNT_BITS'(cnt);
    return r;
  endfunction

  // Random word: draws and weight changes dominate, changes mostly hit stored keys
  function automatic in_word_t make_random_word();
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.opcode = (r < 45) ? OP_DRAW : (r < 85) ? OP_CHANGE : (r < 95) ? OP_ADD : OP_NONE;
    w.key    = KEY_BITS'($urandom);
    if (w.opcode == OP_CHANGE && table_count > 0 && $urandom_range(0, 3) != 0)
      w.key = table_keys[$urandom_range(0, table_count-1)];
    case ($urandom_range(0, 7))
      0:       w.weight = '0;
      1:       w.weight = '1;
      2, 3:    w.weight = WEIGHT_BITS'($urandom_range(0, 15));
      default: w.weight = WEIGHT_BITS'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       w.random_value = '0;
      1:       w.random_value = '1;
      default: w.random_value = RANDOM_BITS'($urandom);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (err_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Offer one word and log its expected result once it is taken
  task automatic send_word(in_word_t w, bit typed, out_word_t typed_exp);
    int        gap;
    out_word_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predicted = apply_to_table(w);
    expected_q = {expected_q, (typed ? typed_exp : predicted)};
  endtask

  // Stimulus
  initial begin
    stim_row_t directed_rows[$];
    stim_row_t row;
    in_word_t  w;
    out_word_t no_exp;
    no_exp = '0;

    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'hFFFF, 1, 1,
                                           16'h0000, ST_EMPTY, 0)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'h0005, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_NOT_FOUND, 0)};
    directed_rows = {directed_rows, mk_row(OP_NONE,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1,
                                           16'h0000, ST_OK, 0)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'h0000, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 1)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'hABCD, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 2)};
    // all weights zero: last entry comes back
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'hFFFF, 1, 1,
                                           16'hABCD, ST_OK, 2)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'hFFFF, 16'hFFFF, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 3)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'h0000, 1, 1,
                                           16'hFFFF, ST_OK, 3)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'hFFFF, 1, 1,
                                           16'hFFFF, ST_OK, 3)};
    // duplicate keys; the change must land on the first copy
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'h1234, 16'h0001, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 4)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'h1234, 16'h0007, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 5)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'hFFFF, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 5)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'h1234, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 5)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'h5555, 16'h0007, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 6)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'h4000, 1, 1,
                                           16'h1234, ST_OK, 6)};
    // running sum equal to the threshold does not select
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'h8000, 1, 1,
                                           16'h5555, ST_OK, 6)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'h0000, 16'hFFFF, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 6)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'hFFFF, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 6)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'h5A5A, 1, 0,
                                           16'h0000, ST_OK, 0)};
    // fill up the table, then hit it while full
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'h0100, 16'h00C3, 16'h0000, 58, 0,
                                           16'h0000, ST_OK, 0)};
    directed_rows = {directed_rows, mk_row(OP_ADD,    16'hDEAD, 16'h0001, 16'h0000, 1, 1,
                                           16'h0000, ST_FULL, 64)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'h0139, 16'hFFFF, 16'h0000, 1, 0,
                                           16'h0000, ST_OK, 0)};
    directed_rows = {directed_rows, mk_row(OP_CHANGE, 16'hBEEF, 16'h0001, 16'h0000, 1, 1,
                                           16'h0000, ST_NOT_FOUND, 64)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'hFFFF, 1, 0,
                                           16'h0000, ST_OK, 0)};
    directed_rows = {directed_rows, mk_row(OP_DRAW,   16'h0000, 16'h0000, 16'h0000, 1, 0,
                                           16'h0000, ST_OK, 0)};
    directed_rows = {directed_rows, mk_row(OP_NONE,   16'h0000, 16'h0000, 16'h0000, 1, 1,
                                           16'h0000, ST_OK, 64)};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int rep = 0; rep < row.reps; rep++) begin
        w     = row.word;
        w.key = row.word.key + KEY_BITS'(rep);
        send_word(w, row.typed, row.exp);
      end
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = ((i / 128) % 3) == 2;
      if (i == 200) hold_req = 1'b1;
      // pause the sender until every result is back
      if (i == 700) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
      end
      send_word(make_random_word(), 1'b0, no_exp);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS roulette_wheel_selector_core");
    end else begin
      $display("FAIL roulette_wheel_selector_core");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    repeat (10) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result word against the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result word", int'(out_data), 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data.selected_key !== want.selected_key)
          report_mismatch("selected_key", int'(out_data.selected_key),
                          int'(want.selected_key));
        if (out_data.status !== want.status)
          report_mismatch("status", int'(out_data.status), int'(want.status));
        if (out_data.item_count !== want.item_count)
          report_mismatch("item_count", int'(out_data.item_count), int'(want.item_count));
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("FAIL roulette_wheel_selector_core");
    $finish;
  end

endmodule
